@@ design/kf1d_pkg.sv @@
// Shared types, constants and helpers for the one-dimensional Kalman filter.
// Used by every module of the block; depends on nothing.
package kf1d_pkg;

  // Data width of every mean and variance (Q16.16).
  localparam int DATA_WIDTH = 32;
  // Step counter for one bit-serial pass over DATA_WIDTH bits.
  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam int CFG_INDEX_W = 3;

  // Register reset values.
  localparam logic [DATA_WIDTH-1:0] MEAS_VAR_RESET = DATA_WIDTH'(4 * 65536);
  localparam logic [DATA_WIDTH-1:0] MOTION_VAR_RESET = DATA_WIDTH'(2 * 65536);
  localparam logic [DATA_WIDTH-1:0] INIT_MEAN_RESET = '0;
  localparam logic [DATA_WIDTH-1:0] INIT_VAR_RESET = DATA_WIDTH'(1000 * 65536);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MEAS_VAR   = 3'd0,
    CFG_MOTION_VAR = 3'd1,
    CFG_INIT_MEAN  = 3'd2,
    CFG_INIT_VAR   = 3'd3
  } cfg_index_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } kf_state_t;

  // Input word: one measurement and one motion step.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] measurement;
    logic signed [DATA_WIDTH-1:0] motion;
    logic                         restart;
  } sample_t;

  // Output word: updated and predicted estimate.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] updated_mean;
    logic        [DATA_WIDTH-1:0] updated_variance;
    logic signed [DATA_WIDTH-1:0] predicted_mean;
    logic        [DATA_WIDTH-1:0] predicted_variance;
  } estimate_t;

  // Control of a bit-serial unit: load operands, or advance one bit.
  typedef struct packed {
    logic load;
    logic step;
  } ser_ctl_t;

  // Magnitude of a two's complement value; the most negative value maps to 2^(W-1).
  function automatic logic [DATA_WIDTH-1:0] mag_of(logic [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

@@ design/kalman_filter_1d.sv @@
// One-dimensional Kalman filter, Q16.16, bit-serial multiply and divide.
// A word is taken only in idle, after the previous word has left the sequencer, and the
// multipliers and dividers work one bit per cycle; a new word is taken while the last
// result waits in the output register.
// Reset (synchronous, rst high) loads register defaults and the initial estimate.
module kalman_filter_1d import kf1d_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  sample_t                sample,
  output logic                   estimate_valid,
  input  logic                   estimate_ready,
  output estimate_t              estimate,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]  cfg_data
);

  // Configuration registers.
  logic [DATA_WIDTH-1:0] meas_var;
  logic [DATA_WIDTH-1:0] motion_var;
  logic [DATA_WIDTH-1:0] init_mean;
  logic [DATA_WIDTH-1:0] init_var;

  // Filter state.
  logic [DATA_WIDTH-1:0] est_mean;
  logic [DATA_WIDTH-1:0] est_var;

  // Sequencer.
  kf_state_t        state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             last_bit;
  ser_ctl_t         mul_ctl, div_ctl;

  // Operands of the word in work.
  logic [DATA_WIDTH-1:0] op_mean;
  logic [DATA_WIDTH-1:0] op_motion;
  logic [DATA_WIDTH:0]   op_sum;
  logic                  neg_mean, neg_meas, neg_out;
  logic [DATA_WIDTH-1:0] upd_mean, upd_var;

  logic                  take;
  logic                  out_free;
  logic [DATA_WIDTH-1:0] sel_mean, sel_var;

  logic [2*DATA_WIDTH-1:0] prod_a, prod_b, prod_v;
  logic [2*DATA_WIDTH:0]   mag;
  logic                    mag_neg;
  logic [DATA_WIDTH-1:0]   quo_mean, quo_var;

  logic [DATA_WIDTH:0]   pm_wide, pv_wide;
  logic [DATA_WIDTH-1:0] pm_sat, pv_sat;

  assign take     = sample_valid && sample_ready;
  assign out_free = !estimate_valid || estimate_ready;
  assign last_bit = cnt == CNT_W'(DATA_WIDTH - 1);

  // A restart word works from the configured initial estimate.
  assign sel_mean = sample.restart ? init_mean : est_mean;
  assign sel_var  = sample.restart ? init_var : est_var;

  // Configuration writes; indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      meas_var   <= MEAS_VAR_RESET;
      motion_var <= MOTION_VAR_RESET;
      init_mean  <= INIT_MEAN_RESET;
      init_var   <= INIT_VAR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MEAS_VAR:   meas_var   <= cfg_data;
        CFG_MOTION_VAR: motion_var <= cfg_data;
        CFG_INIT_MEAN:  init_mean  <= cfg_data;
        CFG_INIT_VAR:   init_var   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Three products run side by side: vm*|m|, ve*|z| and ve*vm.
  kf1d_serial_mul u_mul_mean (
    .clk     (clk),
    .ctl     (mul_ctl),
    .a       (meas_var),
    .b       (mag_of(sel_mean)),
    .product (prod_a)
  );

  kf1d_serial_mul u_mul_meas (
    .clk     (clk),
    .ctl     (mul_ctl),
    .a       (sel_var),
    .b       (mag_of(sample.measurement)),
    .product (prod_b)
  );

  kf1d_serial_mul u_mul_var (
    .clk     (clk),
    .ctl     (mul_ctl),
    .a       (sel_var),
    .b       (meas_var),
    .product (prod_v)
  );

  // Signed sum of the two weighted terms, kept as sign and magnitude.
  always_comb begin
    if (neg_mean == neg_meas) begin
      mag     = {1'b0, prod_a} + {1'b0, prod_b};
      mag_neg = neg_mean;
    end else if (prod_a >= prod_b) begin
      mag     = {1'b0, prod_a - prod_b};
      mag_neg = neg_mean;
    end else begin
      mag     = {1'b0, prod_b - prod_a};
      mag_neg = neg_meas;
    end
  end

  // Both quotients share the total variance as divisor.
  kf1d_serial_div u_div_mean (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (mag),
    .divisor  (op_sum),
    .quotient (quo_mean)
  );

  kf1d_serial_div u_div_var (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend ({1'b0, prod_v}),
    .divisor  (op_sum),
    .quotient (quo_var)
  );

  // Prediction with saturation at the field limits.
  assign pm_wide = {upd_mean[DATA_WIDTH-1], upd_mean} + {op_motion[DATA_WIDTH-1], op_motion};
  assign pv_wide = {1'b0, upd_var} + {1'b0, motion_var};

  always_comb begin
    if (pm_wide[DATA_WIDTH] != pm_wide[DATA_WIDTH-1]) begin
      pm_sat = pm_wide[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                   : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      pm_sat = pm_wide[DATA_WIDTH-1:0];
    end
    pv_sat = pv_wide[DATA_WIDTH] ? {DATA_WIDTH{1'b1}} : pv_wide[DATA_WIDTH-1:0];
  end

  // Next state, bit counter and unit controls; no word is taken during reset.
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    mul_ctl      = '0;
    div_ctl      = '0;
    sample_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_ready = !rst;
        if (sample_valid && !rst) begin
          mul_ctl.load = 1'b1;
          cnt_next     = '0;
          state_next   = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_ctl.step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (last_bit) begin
          state_next = ST_COMB;
        end
      end
      ST_COMB: begin
        div_ctl.load = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        div_ctl.step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (last_bit) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Capture the operands of an accepted word.
  always_ff @(posedge clk) begin
    if (take) begin
      op_mean   <= sel_mean;
      op_motion <= sample.motion;
      op_sum    <= {1'b0, sel_var} + {1'b0, meas_var};
      neg_mean  <= sel_mean[DATA_WIDTH-1];
      neg_meas  <= sample.measurement[DATA_WIDTH-1];
    end
    if (state == ST_COMB) begin
      neg_out <= mag_neg;
    end
  end

  // Updated estimate; with zero total variance the mean is kept and the variance is zero.
  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      if (op_sum == '0) begin
        upd_mean <= op_mean;
        upd_var  <= '0;
      end else begin
        upd_mean <= neg_out ? (~quo_mean + 1'b1) : quo_mean;
        upd_var  <= quo_var;
      end
    end
  end

  // Filter state follows the predicted estimate, or a restart.
  always_ff @(posedge clk) begin
    if (rst) begin
      est_mean <= INIT_MEAN_RESET;
      est_var  <= INIT_VAR_RESET;
    end else if (state == ST_OUT && out_free) begin
      est_mean <= pm_sat;
      est_var  <= pv_sat;
    end
  end

  // Output register, free to hold a word while the next one is in work.
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      estimate_valid <= 1'b1;
    end else if (estimate_ready) begin
      estimate_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      estimate.updated_mean       <= upd_mean;
      estimate.updated_variance   <= upd_var;
      estimate.predicted_mean     <= pm_sat;
      estimate.predicted_variance <= pv_sat;
    end
  end

endmodule

@@ design/kf1d_serial_mul.sv @@
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Depends on kf1d_pkg for the data width and the control struct.
module kf1d_serial_mul import kf1d_pkg::*; (
  input  logic                      clk,
  input  ser_ctl_t                  ctl,
  input  logic [DATA_WIDTH-1:0]     a,
  input  logic [DATA_WIDTH-1:0]     b,
  output logic [2*DATA_WIDTH-1:0]   product
);

  logic [DATA_WIDTH-1:0]   a_reg;
  logic [2*DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH:0]     upper_sum;

  // Add the multiplicand into the upper half when the current multiplier bit is set.
  assign upper_sum = {1'b0, acc[2*DATA_WIDTH-1:DATA_WIDTH]}
                   + (acc[0] ? {1'b0, a_reg} : {(DATA_WIDTH+1){1'b0}});

  // The multiplier shifts out of the low half while the product fills in from the top.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_reg <= a;
      acc   <= {{DATA_WIDTH{1'b0}}, b};
    end else if (ctl.step) begin
      acc <= {upper_sum, acc[DATA_WIDTH-1:1]};
    end
  end

  assign product = acc;

endmodule

@@ design/kf1d_serial_div.sv @@
// Restoring divider, one quotient bit per cycle, for dividends whose quotient
// fits DATA_WIDTH bits. Depends on kf1d_pkg for the data width and control struct.
module kf1d_serial_div import kf1d_pkg::*; (
  input  logic                      clk,
  input  ser_ctl_t                  ctl,
  input  logic [2*DATA_WIDTH:0]     dividend,
  input  logic [DATA_WIDTH:0]       divisor,
  output logic [DATA_WIDTH-1:0]     quotient
);

  logic [DATA_WIDTH:0]   rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH:0]   dvs;
  logic [DATA_WIDTH+1:0] shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                  ge;

  // Bring down the next dividend bit and try the subtraction.
  assign shifted = {rem, quo[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};

  // The high half seeds the remainder; it is below the divisor because the
  // quotient fits. The low half shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= dividend[2*DATA_WIDTH:DATA_WIDTH];
      quo <= dividend[DATA_WIDTH-1:0];
      dvs <= divisor;
    end else if (ctl.step) begin
      rem <= ge ? diff[DATA_WIDTH:0] : shifted[DATA_WIDTH:0];
      quo <= {quo[DATA_WIDTH-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for kalman_filter_1d: directed and random words are checked
// against a bit-accurate predictor of the filter kept inside this module.
// Depends on kf1d_pkg and the kalman_filter_1d RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kf1d_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 2 * DATA_WIDTH + 8;
  localparam int RANDOM_PHASES = 7;
  localparam int WORDS_PER_PHASE = 200;
  localparam int BURST_WORDS = 8;
  localparam int FIRST_UNUSED_INDEX = int'(CFG_INIT_VAR) + 1;
  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;
  localparam logic [DATA_WIDTH-1:0] ONE_Q16 = DATA_WIDTH'(65536);

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   sample_valid;
  logic                   sample_ready;
  sample_t                sample;
  logic                   estimate_valid;
  logic                   estimate_ready;
  estimate_t              estimate;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DATA_WIDTH-1:0]  cfg_data;

  // Mirror of the filter registers and of its running estimate.
  logic [DATA_WIDTH-1:0] meas_var = MEAS_VAR_RESET;
  logic [DATA_WIDTH-1:0] motion_var = MOTION_VAR_RESET;
  logic [DATA_WIDTH-1:0] init_mean = INIT_MEAN_RESET;
  logic [DATA_WIDTH-1:0] init_var = INIT_VAR_RESET;
  logic [DATA_WIDTH-1:0] est_mean = INIT_MEAN_RESET;
  logic [DATA_WIDTH-1:0] est_var = INIT_VAR_RESET;

  estimate_t pending_estimates[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        hold_request = 0;
  bit        steady_flow = 1'b0;

  kalman_filter_1d dut (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample         (sample),
    .estimate_valid (estimate_valid),
    .estimate_ready (estimate_ready),
    .estimate       (estimate),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Measurement update followed by motion prediction; advances the mirrored estimate.
  function automatic estimate_t fuse_and_predict(input sample_t word);
    logic [DATA_WIDTH:0]     total;
    logic [2*DATA_WIDTH+1:0] pull_to_est, pull_to_meas, numer, quot, var_prod;
    logic [DATA_WIDTH-1:0]   mag_m, mag_z, mean_q;
    logic                    neg_m, neg_z, neg;
    logic [DATA_WIDTH:0]     mean_sum, var_sum;
    estimate_t               r;
    if (word.restart) begin
      est_mean = init_mean;
      est_var = init_var;
    end
    total = {1'b0, est_var} + {1'b0, meas_var};
    if (total == '0) begin
      // Both variances zero: no division, the mean passes through.
      r.updated_mean = est_mean;
      r.updated_variance = '0;
    end else begin
      neg_m = est_mean[DATA_WIDTH-1];
      neg_z = word.measurement[DATA_WIDTH-1];
      mag_m = neg_m ? (0 - est_mean) : est_mean;
      mag_z = neg_z ? (0 - word.measurement) : word.measurement;
      pull_to_est = meas_var * mag_m;
      pull_to_meas = est_var * mag_z;
      // Sign-magnitude sum, so that the quotient truncates toward zero.
      if (neg_m == neg_z) begin
        numer = pull_to_est + pull_to_meas;
        neg = neg_m;
      end else if (pull_to_est >= pull_to_meas) begin
        numer = pull_to_est - pull_to_meas;
        neg = neg_m;
      end else begin
        numer = pull_to_meas - pull_to_est;
        neg = neg_z;
      end
      quot = numer / total;
      mean_q = quot[DATA_WIDTH-1:0];
      r.updated_mean = neg ? (0 - mean_q) : mean_q;
      var_prod = est_var * meas_var;
      quot = var_prod / total;
      r.updated_variance = quot[DATA_WIDTH-1:0];
    end
    // Prediction with saturation on both sums.
    mean_sum = {r.updated_mean[DATA_WIDTH-1], r.updated_mean}
             + {word.motion[DATA_WIDTH-1], word.motion};
    if (mean_sum[DATA_WIDTH] != mean_sum[DATA_WIDTH-1])
      r.predicted_mean = mean_sum[DATA_WIDTH] ? MOST_NEG : MOST_POS;
    else
      r.predicted_mean = mean_sum[DATA_WIDTH-1:0];
    var_sum = {1'b0, r.updated_variance} + {1'b0, motion_var};
    r.predicted_variance = var_sum[DATA_WIDTH] ? ALL_ONES : var_sum[DATA_WIDTH-1:0];
    est_mean = r.predicted_mean;
    est_var = r.predicted_variance;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(20, 90);
    return $urandom_range(1, 3);
  endfunction

  function automatic int sender_gap();
    if (steady_flow || $urandom_range(0, 2) == 0)
      return 0;
    return pick_gap();
  endfunction

  // Field values biased toward the extremes.
  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ALL_ONES;
      2: return MOST_NEG;
      3: return MOST_POS;
      4, 5: return DATA_WIDTH'($urandom_range(0, 32'h0010_0000));
      default: return DATA_WIDTH'($urandom());
    endcase
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_variance();
    if ($urandom_range(0, 3) == 0)
      return pick_word();
    return DATA_WIDTH'($urandom_range(1, 32'h0040_0000));
  endfunction

  function automatic logic [DATA_WIDTH-1:0] small_offset(input int unsigned span);
    return DATA_WIDTH'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic sample_t make_word(input logic [DATA_WIDTH-1:0] measurement,
                                        input logic [DATA_WIDTH-1:0] motion,
                                        input logic restart);
    sample_t word;
    word.measurement = measurement;
    word.motion = motion;
    word.restart = restart;
    return word;
  endfunction

  // Offer one word, and record its expected estimate once it is taken.
  task automatic send_word(input sample_t word);
    int gap;
    gap = sender_gap();
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample <= word;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    pending_estimates.push_back(fuse_and_predict(word));
    @(negedge clk);
  endtask

  // Stop offering words and let every expected estimate come back.
  task automatic wait_for_estimates();
    sample_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [DATA_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    case (index)
      CFG_MEAS_VAR:   meas_var = data;
      CFG_MOTION_VAR: motion_var = data;
      CFG_INIT_MEAN:  init_mean = data;
      CFG_INIT_VAR:   init_var = data;
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [DATA_WIDTH-1:0] mv, input logic [DATA_WIDTH-1:0] mo,
                                input logic [DATA_WIDTH-1:0] im, input logic [DATA_WIDTH-1:0] iv);
    write_reg(CFG_MEAS_VAR, mv);
    write_reg(CFG_MOTION_VAR, mo);
    write_reg(CFG_INIT_MEAN, im);
    write_reg(CFG_INIT_VAR, iv);
  endtask

  // Estimate after reset, and saturation of the predicted mean in both directions.
  task automatic test_reset_state();
    send_word(make_word('0, '0, 1'b0));
    send_word(make_word(MOST_POS, MOST_POS, 1'b0));
    send_word(make_word(MOST_NEG, MOST_NEG, 1'b0));
    send_word(make_word(DATA_WIDTH'($urandom()), '0, 1'b1));
  endtask

  // Zero total variance, then zero measurement variance alone.
  task automatic test_zero_variance();
    wait_for_estimates();
    write_settings('0, '0, DATA_WIDTH'(32'h0003_8000), '0);
    send_word(make_word(DATA_WIDTH'($urandom()), small_offset(1 << 16), 1'b1));
    send_word(make_word(MOST_NEG, '0, 1'b0));
    wait_for_estimates();
    write_reg(CFG_INIT_VAR, ONE_Q16);
    send_word(make_word(DATA_WIDTH'(32'h0012_3456), '0, 1'b1));
    send_word(make_word(MOST_NEG, '0, 1'b1));
  endtask

  // Register extremes: widest products, opposite signs, variance saturation.
  task automatic test_register_extremes();
    wait_for_estimates();
    write_settings(ALL_ONES, ALL_ONES, MOST_NEG, ALL_ONES);
    send_word(make_word(MOST_POS, MOST_POS, 1'b1));
    send_word(make_word(MOST_NEG, MOST_NEG, 1'b0));
    wait_for_estimates();
    write_reg(CFG_INIT_MEAN, MOST_POS);
    send_word(make_word(MOST_POS, MOST_POS, 1'b1));
    send_word(make_word(MOST_NEG, MOST_POS, 1'b0));
    wait_for_estimates();
    write_settings(DATA_WIDTH'(1), '0, MOST_POS, '0);
    send_word(make_word(MOST_NEG, MOST_NEG, 1'b1));
  endtask

  // Writes to indexes past the last register must change nothing.
  task automatic test_unused_indexes();
    wait_for_estimates();
    for (int idx = FIRST_UNUSED_INDEX; idx < (1 << CFG_INDEX_W); idx++)
      write_reg(CFG_INDEX_W'(idx), ALL_ONES);
    send_word(make_word(DATA_WIDTH'($urandom()), DATA_WIDTH'($urandom()), 1'b1));
    send_word(make_word(DATA_WIDTH'($urandom()), DATA_WIDTH'($urandom()), 1'b0));
    wait_for_estimates();
    write_settings(MEAS_VAR_RESET, MOTION_VAR_RESET, INIT_MEAN_RESET, INIT_VAR_RESET);
    send_word(make_word(small_offset(1 << 20), small_offset(1 << 16), 1'b1));
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    wait_for_estimates();
    steady_flow = 1'b1;
    hold_request = LONG_HOLD_CYCLES;
    for (int n = 0; n < BURST_WORDS; n++)
      send_word(make_word(DATA_WIDTH'($urandom()), small_offset(1 << 16), 1'b0));
    steady_flow = 1'b0;
  endtask

  // Tracking runs: a target moves by the commanded motion and is measured with noise,
  // mixed with arbitrary words and occasional restarts.
  task automatic test_random_phases();
    sample_t               word;
    logic [DATA_WIDTH-1:0] track;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_estimates();
      steady_flow = (phase % 3 == 2);
      case (phase)
        0: write_settings(ALL_ONES, ALL_ONES, MOST_NEG, ALL_ONES);
        1: write_settings(DATA_WIDTH'(1), '0, MOST_POS, '0);
        default: write_settings(pick_variance(), pick_variance(), pick_word(), pick_variance());
      endcase
      track = init_mean;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        word.restart = (n == 0) || ($urandom_range(0, 31) == 0);
        if (word.restart)
          track = init_mean;
        word.motion = ($urandom_range(0, 7) == 0) ? pick_word() : small_offset(1 << 17);
        track = track + word.motion;
        word.measurement = ($urandom_range(0, 4) == 0) ? pick_word()
                                                        : track + small_offset(1 << 20);
        send_word(word);
      end
    end
    steady_flow = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] want,
                             input logic [DATA_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each estimate word taken against the oldest expectation.
  always @(posedge clk) begin : check_estimates
    estimate_t want;
    if (!rst && estimate_valid && estimate_ready) begin
      if (pending_estimates.size() == 0) begin
        $error("estimate word %h arrived with none expected", estimate);
        mismatches++;
      end else begin
        want = pending_estimates.pop_front();
        check_field("updated_mean", want.updated_mean, estimate.updated_mean);
        check_field("updated_variance", want.updated_variance, estimate.updated_variance);
        check_field("predicted_mean", want.predicted_mean, estimate.predicted_mean);
        check_field("predicted_variance", want.predicted_variance,
                    estimate.predicted_variance);
      end
    end
  end

  // Receiver: random stalls, plus one long hold when a test asks for it.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    estimate_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (hold_request != 0) begin
          stall_left = hold_request;
          hold_request = 0;
        end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
      if (rst || stall_left != 0) begin
        estimate_ready <= 1'b0;
        if (stall_left != 0)
          stall_left--;
      end else begin
        estimate_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (estimate_valid && estimate_ready) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_state();
    test_zero_variance();
    test_register_extremes();
    test_unused_indexes();
    test_backpressure();
    test_random_phases();
    wait_for_estimates();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
